FILE: sv/wclk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wclk_pkg;

  localparam int NUM_COLS   = 11;
  localparam int NUM_ROWS   = 10;
  localparam int FRAME_ROWS = NUM_ROWS + 1;

  localparam logic [3:0] LAST_ROW = 4'(NUM_ROWS);

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  // First five-minute slot from which the next hour is named.
  localparam logic [3:0] HALF_TURN_SLOT = 4'd5;
  localparam logic [3:0] SLOT_COUNT     = 4'd12;

  typedef logic [4:0] word_t;
  typedef logic [NUM_COLS-1:0] row_mask_t;
  typedef logic [FRAME_ROWS-1:0][NUM_COLS-1:0] frame_t;

  localparam int W_COUNT = 23;

  localparam word_t W_ES          = 5'd0;
  localparam word_t W_IST         = 5'd1;
  localparam word_t W_MIN_FIVE    = 5'd2;
  localparam word_t W_MIN_TEN     = 5'd3;
  localparam word_t W_MIN_TWENTY  = 5'd4;
  localparam word_t W_QUARTER     = 5'd5;
  localparam word_t W_NACH        = 5'd6;
  localparam word_t W_VOR         = 5'd7;
  localparam word_t W_HALB        = 5'd8;
  localparam word_t W_UHR         = 5'd9;
  localparam word_t W_EIN         = 5'd10;
  localparam word_t W_EINS        = 5'd11;
  localparam word_t W_ZWEI        = 5'd12;
  localparam word_t W_DREI        = 5'd13;
  localparam word_t W_VIER        = 5'd14;
  localparam word_t W_HOUR_FIVE   = 5'd15;
  localparam word_t W_SECHS       = 5'd16;
  localparam word_t W_HOUR_SEVEN  = 5'd17;
  localparam word_t W_ACHT        = 5'd18;
  localparam word_t W_NEUN        = 5'd19;
  localparam word_t W_HOUR_TEN    = 5'd20;
  localparam word_t W_ELF         = 5'd21;
  localparam word_t W_HOUR_TWELVE = 5'd22;

  // Letter row of a word on the front plate.
  function automatic logic [3:0] word_row(input word_t w);
    logic [3:0] r;
    unique case (w)
      W_ES, W_IST, W_MIN_FIVE:                r = 4'd0;
      W_MIN_TEN, W_MIN_TWENTY:                r = 4'd1;
      W_QUARTER:                              r = 4'd2;
      W_NACH, W_VOR:                          r = 4'd3;
      W_HALB, W_HOUR_TWELVE:                  r = 4'd4;
      W_EIN, W_EINS, W_ZWEI, W_HOUR_SEVEN:    r = 4'd5;
      W_DREI, W_HOUR_FIVE:                    r = 4'd6;
      W_VIER, W_NEUN, W_ELF:                  r = 4'd7;
      W_ACHT, W_HOUR_TEN:                     r = 4'd8;
      W_UHR, W_SECHS:                         r = 4'd9;
      default:                                r = 4'd0;
    endcase
    return r;
  endfunction

  // Letters of a word, bit k being column k counted from the left.
  function automatic row_mask_t word_mask(input word_t w);
    logic [3:0] col;
    logic [3:0] len;
    unique case (w)
      W_ES:          begin col = 4'd0; len = 4'd2; end
      W_IST:         begin col = 4'd3; len = 4'd3; end
      W_MIN_FIVE:    begin col = 4'd7; len = 4'd4; end
      W_MIN_TEN:     begin col = 4'd0; len = 4'd4; end
      W_MIN_TWENTY:  begin col = 4'd4; len = 4'd7; end
      W_QUARTER:     begin col = 4'd4; len = 4'd7; end
      W_NACH:        begin col = 4'd2; len = 4'd4; end
      W_VOR:         begin col = 4'd7; len = 4'd3; end
      W_HALB:        begin col = 4'd0; len = 4'd4; end
      W_UHR:         begin col = 4'd8; len = 4'd3; end
      W_EIN:         begin col = 4'd2; len = 4'd3; end
      W_EINS:        begin col = 4'd2; len = 4'd4; end
      W_ZWEI:        begin col = 4'd0; len = 4'd4; end
      W_DREI:        begin col = 4'd0; len = 4'd4; end
      W_VIER:        begin col = 4'd7; len = 4'd4; end
      W_HOUR_FIVE:   begin col = 4'd7; len = 4'd4; end
      W_SECHS:       begin col = 4'd0; len = 4'd5; end
      W_HOUR_SEVEN:  begin col = 4'd5; len = 4'd6; end
      W_ACHT:        begin col = 4'd1; len = 4'd4; end
      W_NEUN:        begin col = 4'd3; len = 4'd4; end
      W_HOUR_TEN:    begin col = 4'd6; len = 4'd4; end
      W_ELF:         begin col = 4'd0; len = 4'd3; end
      W_HOUR_TWELVE: begin col = 4'd5; len = 4'd5; end
      default:       begin col = 4'd0; len = 4'd0; end
    endcase
    return row_mask_t'((row_mask_t'(1) << len) - row_mask_t'(1)) << col;
  endfunction

  // Hour word for dial hours two to twelve.
  function automatic word_t hour_word(input logic [3:0] h);
    word_t w;
    unique case (h)
      4'd2:    w = W_ZWEI;
      4'd3:    w = W_DREI;
      4'd4:    w = W_VIER;
      4'd5:    w = W_HOUR_FIVE;
      4'd6:    w = W_SECHS;
      4'd7:    w = W_HOUR_SEVEN;
      4'd8:    w = W_ACHT;
      4'd9:    w = W_NEUN;
      4'd10:   w = W_HOUR_TEN;
      4'd11:   w = W_ELF;
      default: w = W_HOUR_TWELVE;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/wclk_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module wclk_decode (
  input  wire logic [4:0]      hour_of_day,
  input  wire logic [5:0]      minute_of_hour,
  output wclk_pkg::frame_t     frame
);

  logic [9:0]                  min_x13;
  logic [3:0]                  slot;
  logic [5:0]                  slot_x5;
  logic [2:0]                  rest;
  logic [4:0]                  hour_base;
  logic [3:0]                  h_dial;
  logic [3:0]                  h_shown;
  logic                        words_on;
  logic [wclk_pkg::W_COUNT-1:0] word_en;
  wclk_pkg::row_mask_t         cols [wclk_pkg::NUM_ROWS];

  // floor(minute / 5) is exact as (minute * 13) >> 6 over the whole 6-bit range.
  assign min_x13  = 10'(minute_of_hour) * 10'd13;
  assign slot     = min_x13[9:6];
  assign slot_x5  = 6'({slot, 2'b00}) + 6'(slot);
  assign rest     = 3'(minute_of_hour - slot_x5);
  assign words_on = (slot < wclk_pkg::SLOT_COUNT);

  always_comb begin
    if (hour_of_day >= 5'd24) begin
      hour_base = hour_of_day - 5'd24;
    end else if (hour_of_day >= 5'd12) begin
      hour_base = hour_of_day - 5'd12;
    end else begin
      hour_base = hour_of_day;
    end
    h_dial = (hour_base == 5'd0) ? 4'd12 : hour_base[3:0];
    if (slot >= wclk_pkg::HALF_TURN_SLOT) begin
      h_shown = (h_dial == 4'd12) ? 4'd1 : h_dial + 4'd1;
    end else begin
      h_shown = h_dial;
    end
  end

  always_comb begin
    word_en = '0;
    word_en[wclk_pkg::W_ES]  = 1'b1;
    word_en[wclk_pkg::W_IST] = 1'b1;
    unique case (slot)
      4'd1: begin
        word_en[wclk_pkg::W_MIN_FIVE] = 1'b1;
        word_en[wclk_pkg::W_NACH]     = 1'b1;
      end
      4'd2: begin
        word_en[wclk_pkg::W_MIN_TEN] = 1'b1;
        word_en[wclk_pkg::W_NACH]    = 1'b1;
      end
      4'd3: begin
        word_en[wclk_pkg::W_QUARTER] = 1'b1;
        word_en[wclk_pkg::W_NACH]    = 1'b1;
      end
      4'd4: begin
        word_en[wclk_pkg::W_MIN_TWENTY] = 1'b1;
        word_en[wclk_pkg::W_NACH]       = 1'b1;
      end
      4'd5: begin
        word_en[wclk_pkg::W_MIN_FIVE] = 1'b1;
        word_en[wclk_pkg::W_VOR]      = 1'b1;
        word_en[wclk_pkg::W_HALB]     = 1'b1;
      end
      4'd6: begin
        word_en[wclk_pkg::W_HALB] = 1'b1;
      end
      4'd7: begin
        word_en[wclk_pkg::W_MIN_FIVE] = 1'b1;
        word_en[wclk_pkg::W_NACH]     = 1'b1;
        word_en[wclk_pkg::W_HALB]     = 1'b1;
      end
      4'd8: begin
        word_en[wclk_pkg::W_MIN_TWENTY] = 1'b1;
        word_en[wclk_pkg::W_VOR]        = 1'b1;
      end
      4'd9: begin
        word_en[wclk_pkg::W_QUARTER] = 1'b1;
        word_en[wclk_pkg::W_VOR]     = 1'b1;
      end
      4'd10: begin
        word_en[wclk_pkg::W_MIN_TEN] = 1'b1;
        word_en[wclk_pkg::W_VOR]     = 1'b1;
      end
      4'd11: begin
        word_en[wclk_pkg::W_MIN_FIVE] = 1'b1;
        word_en[wclk_pkg::W_VOR]      = 1'b1;
      end
      default: begin
      end
    endcase
    if (words_on) begin
      if (h_shown == 4'd1) begin
        if (slot == 4'd0) begin
          word_en[wclk_pkg::W_EIN] = 1'b1;
        end else begin
          word_en[wclk_pkg::W_EINS] = 1'b1;
        end
      end else begin
        word_en[wclk_pkg::hour_word(h_shown)] = 1'b1;
      end
      if (slot == 4'd0) begin
        word_en[wclk_pkg::W_UHR] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < wclk_pkg::NUM_ROWS; r++) begin
      cols[r] = '0;
    end
    for (int w = 0; w < wclk_pkg::W_COUNT; w++) begin
      if (word_en[w]) begin
        cols[wclk_pkg::word_row(wclk_pkg::word_t'(w))] =
          cols[wclk_pkg::word_row(wclk_pkg::word_t'(w))] |
          wclk_pkg::word_mask(wclk_pkg::word_t'(w));
      end
    end
  end

  // The strip runs in a serpentine, so odd rows are wired right to left.
  always_comb begin
    for (int r = 0; r < wclk_pkg::NUM_ROWS; r++) begin
      for (int k = 0; k < wclk_pkg::NUM_COLS; k++) begin
        if (r % 2 == 0) begin
          frame[r][k] = cols[r][k];
        end else begin
          frame[r][k] = cols[r][wclk_pkg::NUM_COLS-1-k];
        end
      end
    end
    frame[wclk_pkg::NUM_ROWS] =
      wclk_pkg::row_mask_t'((wclk_pkg::row_mask_t'(1) << rest) - wclk_pkg::row_mask_t'(1));
  end

endmodule

`default_nettype wire

FILE: sv/wclk_serial.sv
`timescale 1ns / 1ps
`default_nettype none

module wclk_serial (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             frame_valid,
  output      logic             frame_ready,
  input  wire wclk_pkg::frame_t frame,
  input  wire logic [23:0]      color,
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  output      logic [39:0]      out_tdata,
  output      logic             out_tlast
);

  wclk_pkg::frame_t    frame_r, frame_nxt;
  logic                frame_vld_r, frame_vld_nxt;
  logic [3:0]          row_cnt_r, row_cnt_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [3:0]          out_row_r;
  wclk_pkg::row_mask_t out_mask_r;
  logic [23:0]         out_color_r;
  logic                out_last_r;
  logic                out_free;
  logic                emit;
  logic                last_emit;
  logic                load;

  assign out_free    = !out_vld_r || out_tready;
  assign emit        = frame_vld_r && out_free;
  assign last_emit   = emit && (row_cnt_r == wclk_pkg::LAST_ROW);
  assign frame_ready = !frame_vld_r || last_emit;
  assign load        = frame_valid && frame_ready;

  always_comb begin
    frame_nxt     = frame_r;
    frame_vld_nxt = frame_vld_r;
    row_cnt_nxt   = row_cnt_r;
    if (load) begin
      frame_nxt     = frame;
      frame_vld_nxt = 1'b1;
      row_cnt_nxt   = '0;
    end else if (last_emit) begin
      frame_vld_nxt = 1'b0;
      row_cnt_nxt   = '0;
    end else if (emit) begin
      frame_nxt   = wclk_pkg::frame_t'(frame_r >> wclk_pkg::NUM_COLS);
      row_cnt_nxt = row_cnt_r + 4'd1;
    end
    out_vld_nxt = out_free ? frame_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_vld_r <= 1'b0;
      row_cnt_r   <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      frame_vld_r <= frame_vld_nxt;
      row_cnt_r   <= row_cnt_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (emit) begin
      out_row_r   <= row_cnt_r;
      out_mask_r  <= frame_r[0];
      out_color_r <= color;
      out_last_r  <= (row_cnt_r == wclk_pkg::LAST_ROW);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_color_r, out_mask_r, out_row_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r <= wclk_pkg::LAST_ROW)
    else $error("row counter ran past the dots row");

  a_idle_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_vld_r |-> row_cnt_r == 4'd0)
    else $error("row counter not rewound while no frame is held");

  a_frame_kept: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !last_emit |=> frame_vld_r && row_cnt_r == $past(row_cnt_r) + 4'd1)
    else $error("frame dropped before its dots row was sent");

  a_last_is_dots: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_last_r |-> out_row_r == wclk_pkg::LAST_ROW)
    else $error("end of frame flagged on a letter row");
`endif

endmodule

`default_nettype wire

FILE: sv/german_word_clock_led_mask_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Word contents (low bit first)
// in_      slave      tdata: hour_of_day[4:0], minute_of_hour[10:5]
// out_     master     tdata: row_number[3:0], row_mask[14:4], pixel_color[38:15];
//                     tlast: last_row
// cfg_     write      index 0 red, 1 green, 2 blue; data 8 bits
//
// Each time word yields eleven output words, rows 0 to 9 then the dots row, one per cycle
// unless out_tready stalls; the single output row port sets the sustained input rate.
// Input register, decoded frame and output register are separate, so the next time word
// is taken while the previous frame is still being sent.
// Reset is synchronous and active low; colors return to full white.
// A stall on out_tready holds the output word and backs up into the input channel.

module german_word_clock_led_mask_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // hour_of_day, minute_of_hour
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // row_number, row_mask, pixel_color
  output      logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic             in_vld_r, in_vld_nxt;
  logic [4:0]       hour_r;
  logic [5:0]       minute_r;
  logic [7:0]       red_r, green_r, blue_r;
  logic             frame_ready;
  wclk_pkg::frame_t frame;

  assign in_tready  = !in_vld_r || frame_ready;
  assign in_vld_nxt = in_tready ? in_tvalid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hour_r   <= in_tdata[4:0];
      minute_r <= in_tdata[10:5];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r   <= 8'hFF;
      green_r <= 8'hFF;
      blue_r  <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wclk_pkg::REG_RED:   red_r   <= cfg_wdata;
        wclk_pkg::REG_GREEN: green_r <= cfg_wdata;
        wclk_pkg::REG_BLUE:  blue_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  wclk_decode u_decode (
    .hour_of_day    (hour_r),
    .minute_of_hour (minute_r),
    .frame          (frame)
  );

  wclk_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (in_vld_r),
    .frame_ready (frame_ready),
    .frame       (frame),
    .color       ({red_r, green_r, blue_r}),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire
